// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, quiet while arst_n is low.
`define TLQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, written as an antecedent and a consequent on the same edge.
`define TLQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: design/tlq_pkg.sv
`timescale 1ns / 1ps

package tlq_pkg;

	localparam int SAMPLE_WIDTH = 32;
	localparam int IDX_W        = 5;
	localparam int CNT_W        = 5;
	localparam int STEP_W       = 5;
	localparam int IN_TDATA_W   = 40;
	localparam int OUT_TDATA_W  = 40;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam int GRP_SIZE     = 8;
	localparam int GRP_CNT_W    = 4;

	typedef enum logic [1:0] {
		ACT_QUANT = 2'd0,
		ACT_THR   = 2'd1,
		ACT_LVL   = 2'd2
	} action_t;

	typedef enum logic {
		REG_THR_COUNT     = 1'b0,
		REG_CUSTOM_LEVELS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                    en;
		logic [IDX_W-1:0]        idx;
		logic [SAMPLE_WIDTH-1:0] data;
	} thr_wr_t;

endpackage

// File: design/tlq_thr_bank.sv
`timescale 1ns / 1ps

module tlq_thr_bank import tlq_pkg::*; #(
	parameter int MAX_THRESHOLDS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  thr_wr_t                   wr,
	input  logic [CNT_W-1:0]          count,
	input  logic [SAMPLE_WIDTH-1:0]   sample,
	output logic [MAX_THRESHOLDS-1:0] below
);

	logic [SAMPLE_WIDTH-1:0] thr_q [MAX_THRESHOLDS];
	logic [31:0]             n_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_THRESHOLDS; i++) begin
				thr_q[i] <= '0;
			end
		end else if (wr.en) begin
			for (int i = 0; i < MAX_THRESHOLDS; i++) begin
				if (32'(wr.idx) == 32'(i)) begin
					thr_q[i] <= wr.data;
				end
			end
		end
	end

	// count saturates at the table depth
	assign n_act = (32'(count) > 32'(MAX_THRESHOLDS)) ? 32'(MAX_THRESHOLDS) : 32'(count);

	always_comb begin
		for (int i = 0; i < MAX_THRESHOLDS; i++) begin
			below[i] = (32'(i) < n_act) && ($signed(thr_q[i]) < $signed(sample));
		end
	end

endmodule

// File: design/threshold_list_quantizer.sv
// Threshold-list quantizer. Each input word either writes a threshold
// (action 1), writes an output level (action 2), or quantizes a signed
// Q16.16 sample (action 0); only samples produce an output word, carrying
// the count k of active thresholds below the sample and either level[k]
// or k in Q16.16. One word per clock is sustained while m_tready does not
// hold the output; a sample's result passes the registered parallel
// threshold compare, two registered popcount stages, the registered read
// of the level memory and the output register. A threshold write affects
// the next word; level entries must be written before a sample reads them.
`timescale 1ns / 1ps

module threshold_list_quantizer import tlq_pkg::*; #(
	parameter int MAX_THRESHOLDS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // action[1:0], entry_index[6:2], value[38:7]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // level_out[31:0], step_index[36:32]
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	`include "assert_macros.svh"

	localparam int LEVEL_DEPTH = MAX_THRESHOLDS + 1;
	localparam int K_W         = $clog2(MAX_THRESHOLDS + 1);
	localparam int GRP_N       = (MAX_THRESHOLDS + GRP_SIZE - 1) / GRP_SIZE;

	// config
	logic [CNT_W-1:0] count_q;
	logic             custom_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= CNT_W'(1);
			custom_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[2]))
				REG_THR_COUNT:     count_q  <= pwdata[CNT_W-1:0];
				REG_CUSTOM_LEVELS: custom_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_THR_COUNT:     prdata = APB_DATA_W'(count_q);
			REG_CUSTOM_LEVELS: prdata = APB_DATA_W'(custom_q);
			default:           prdata = '0;
		endcase
	end

	// input unpack
	logic [1:0]              s_action;
	logic [IDX_W-1:0]        s_idx;
	logic [SAMPLE_WIDTH-1:0] s_value;
	logic                    s_acc;

	assign s_action = s_tdata[1:0];
	assign s_idx    = s_tdata[IDX_W+1:2];
	assign s_value  = s_tdata[SAMPLE_WIDTH+IDX_W+1:IDX_W+2];
	assign s_acc    = s_tvalid && s_tready;

	// threshold bank
	thr_wr_t                   thr_wr;
	logic [MAX_THRESHOLDS-1:0] below;

	assign thr_wr.en   = s_acc && (s_action == ACT_THR);
	assign thr_wr.idx  = s_idx;
	assign thr_wr.data = s_value;

	tlq_thr_bank #(
		.MAX_THRESHOLDS(MAX_THRESHOLDS)
	) u_thr_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (thr_wr),
		.count  (count_q),
		.sample (s_value),
		.below  (below)
	);

	// stage payloads
	logic                    smp_s1, smp_s2, smp_s3;
	logic                    wok_s1, wok_s2, wok_s3;
	logic [K_W-1:0]          wa_s1, wa_s2, wa_s3;
	logic [SAMPLE_WIDTH-1:0] wd_s1, wd_s2, wd_s3;
	logic [GRP_N*GRP_SIZE-1:0] cmp_next, cmp_s1;
	logic [GRP_CNT_W-1:0]    grp_next [GRP_N];
	logic [GRP_CNT_W-1:0]    grp_s2 [GRP_N];
	logic [K_W-1:0]          k_next, k_s3, k_s4;
	logic [SAMPLE_WIDTH-1:0] rd_q;
	logic [SAMPLE_WIDTH-1:0] level_q;
	logic [STEP_W-1:0]       step_q;

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic r1, r2, r3, r4, r_out;

	assign r_out    = !out_v_q || m_tready;
	assign r4       = !v_s4 || r_out;
	assign r3       = !v_s3 || r4;
	assign r2       = !v_s2 || r3;
	assign r1       = !v_s1 || r2;
	assign s_tready = r1;

	logic enter;
	assign enter = s_acc && ((s_action == ACT_QUANT) || (s_action == ACT_LVL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (r1) v_s1 <= enter;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3 && smp_s3;
			if (r_out) out_v_q <= v_s4;
		end
	end

	always_comb begin
		cmp_next = '0;
		for (int i = 0; i < MAX_THRESHOLDS; i++) begin
			cmp_next[i] = below[i];
		end
	end

	always_comb begin
		for (int g = 0; g < GRP_N; g++) begin
			grp_next[g] = '0;
			for (int b = 0; b < GRP_SIZE; b++) begin
				grp_next[g] = grp_next[g] + GRP_CNT_W'(cmp_s1[g*GRP_SIZE+b]);
			end
		end
	end

	always_comb begin
		k_next = '0;
		for (int g = 0; g < GRP_N; g++) begin
			k_next = k_next + K_W'(grp_s2[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (r1) begin
			smp_s1 <= (s_action == ACT_QUANT);
			wok_s1 <= (32'(s_idx) < 32'(LEVEL_DEPTH));
			wa_s1  <= K_W'(s_idx);
			wd_s1  <= s_value;
			cmp_s1 <= cmp_next;
		end
		if (r2) begin
			smp_s2 <= smp_s1;
			wok_s2 <= wok_s1;
			wa_s2  <= wa_s1;
			wd_s2  <= wd_s1;
			grp_s2 <= grp_next;
		end
		if (r3) begin
			smp_s3 <= smp_s2;
			wok_s3 <= wok_s2;
			wa_s3  <= wa_s2;
			wd_s3  <= wd_s2;
			k_s3   <= k_next;
		end
		if (r4) begin
			k_s4 <= k_s3;
		end
		if (r_out && v_s4) begin
			level_q <= custom_q ? rd_q : SAMPLE_WIDTH'({k_s4, 16'b0});
			step_q  <= STEP_W'(k_s4);
		end
	end

	// level memory: writes and reads both issue from s3, in order
	logic [SAMPLE_WIDTH-1:0] lvl_mem [LEVEL_DEPTH];
	logic                    mem_we, mem_re;

	assign mem_we = v_s3 && r4 && !smp_s3 && wok_s3;
	assign mem_re = v_s3 && r4 && smp_s3;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lvl_mem[wa_s3] <= wd_s3;
		end
		if (mem_re) begin
			rd_q <= lvl_mem[k_s3];
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_TDATA_W'({step_q, level_q});

	`TLQ_ASSERT_IMPL(a_step_range, m_tvalid, 32'(step_q) <= 32'(MAX_THRESHOLDS), "step index above table depth")
	`TLQ_ASSERT_IMPL(a_plain_level, m_tvalid && !custom_q, level_q == SAMPLE_WIDTH'({step_q, 16'b0}), "plain level differs from step")
	`TLQ_ASSERT(a_thr_no_result, s_acc && (s_action == ACT_THR) |=> !v_s1, "threshold write entered pipeline")

endmodule
